### rtl/rrpo_pkg.sv
`timescale 1ns / 1ps
package rrpo_pkg;

  localparam int MAX_PATCHES_DEF = 16;
  localparam logic [15:0] PATCH_LIMIT = 16'h8000;
  localparam int COUNT_FIELD_W = 5;

  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_ADD   = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  typedef struct packed {
    logic [15:0] addr;
    logic [7:0]  value;
    logic        cen;
    logic [7:0]  cval;
  } entry_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] addr;
    logic [7:0]  mem;
    logic        hit;
    logic [7:0]  data;
  } query_t;

endpackage

### rtl/rom_read_patch_overlay.sv
`timescale 1ns / 1ps
// patch overlay on the cartridge read path
// input channel: in_valid / in_stall carry one transaction of action, address,
// mem_data, patch_value, compare_enable and compare_value
// output channel: out_valid / out_stall carry one result transaction per input
// add, clear and unused actions: result registered in the cycle after acceptance
// read: the query walks the row of patch cells from newest to oldest, one cell
// per cycle, and the result is registered once it leaves the last cell
// a read occupies the cell row; the next transaction is taken once it returns
// throughput: one transaction per cycle for adds and clears while no read is in
// the cell row and the output is not stalled; reads never overlap in the row
// reset empties the table (count to zero) and drops any transaction in flight
// while the receiver stalls the result register holds and in_stall is raised
// once a further result would have nowhere to go
module rom_read_patch_overlay #(
  parameter int MAX_PATCHES = rrpo_pkg::MAX_PATCHES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [15:0] address,
  input  logic [7:0]  mem_data,
  input  logic [7:0]  patch_value,
  input  logic        compare_enable,
  input  logic [7:0]  compare_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  read_data,
  output logic        was_patched,
  output logic [1:0]  add_status,
  output logic [4:0]  patch_count
);
  import rrpo_pkg::*;

  localparam int CNT_W = $clog2(MAX_PATCHES + 1);
  localparam int IDX_W = (MAX_PATCHES > 1) ? $clog2(MAX_PATCHES) : 1;

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_SEARCH = 2'b10
  } state_t;

  state_t state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic             in_acc;
  logic             out_free;
  logic             do_add;
  status_t          status;
  entry_t           wr_entry;
  logic [IDX_W-1:0] wr_idx;
  query_t           q [0:MAX_PATCHES];
  logic [MAX_PATCHES-1:0] chain_valid;
  logic [CNT_W+COUNT_FIELD_W-1:0] count_wide;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state == S_SEARCH) || !out_free;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    status = ST_OK;
    do_add = 1'b0;
    count_next = count;
    if (in_acc) begin
      unique case (action_t'(action))
        ACT_ADD: begin
          if (address >= PATCH_LIMIT) begin
            status = ST_RANGE;
          end else if (count >= CNT_W'(MAX_PATCHES)) begin
            status = ST_FULL;
          end else begin
            do_add = 1'b1;
            count_next = count + CNT_W'(1);
          end
        end
        ACT_CLEAR: count_next = '0;
        ACT_READ, ACT_NONE: ;
        default: ;
      endcase
    end
  end

  assign wr_idx = count[IDX_W-1:0];
  assign wr_entry = '{addr: address, value: patch_value, cen: compare_enable,
                      cval: compare_value};

  always_comb begin
    q[MAX_PATCHES] = '{valid: in_acc && (action_t'(action) == ACT_READ), addr: address,
                       mem: mem_data, hit: 1'b0, data: mem_data};
  end

  for (genvar i = 0; i < MAX_PATCHES; i++) begin : g_cell
    rrpo_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .wr_en    (do_add && (wr_idx == IDX_W'(i))),
      .wr_entry (wr_entry),
      .active   (count > CNT_W'(i)),
      .q_in     (q[i+1]),
      .q_out    (q[i])
    );
    assign chain_valid[i] = q[i].valid;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (q[MAX_PATCHES].valid) begin
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (q[0].valid) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  assign count_wide = {{COUNT_FIELD_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q[0].valid) begin
      out_valid <= 1'b1;
    end else if (in_acc && (action_t'(action) != ACT_READ)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q[0].valid) begin
      read_data   <= q[0].data;
      was_patched <= q[0].hit;
      add_status  <= ST_OK;
      patch_count <= count_wide[COUNT_FIELD_W-1:0];
    end else if (in_acc && (action_t'(action) != ACT_READ)) begin
      read_data   <= '0;
      was_patched <= 1'b0;
      add_status  <= status;
      patch_count <= count_wide[COUNT_FIELD_W-1:0];
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_PATCHES))
    else $error("patch count above table size");

  a_one_query: assert property (@(posedge clk) disable iff (rst)
    $onehot0(chain_valid))
    else $error("more than one read in the cell row");

  a_search_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH) |-> in_stall && !q[MAX_PATCHES].valid)
    else $error("transaction accepted during a search");

  a_patched_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && was_patched) |-> (add_status == ST_OK))
    else $error("patched read with add status");

endmodule

### rtl/rrpo_cell.sv
`timescale 1ns / 1ps
module rrpo_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  rrpo_pkg::entry_t wr_entry,
  input  logic            active,
  input  rrpo_pkg::query_t q_in,
  output rrpo_pkg::query_t q_out
);
  import rrpo_pkg::*;

  entry_t entry;
  query_t q_next;
  logic   match;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry <= wr_entry;
    end
  end

  always_comb begin
    match = q_in.valid && !q_in.hit && active && (entry.addr == q_in.addr) &&
            (!entry.cen || (entry.cval == q_in.mem));
    q_next = q_in;
    if (match) begin
      q_next.hit  = 1'b1;
      q_next.data = entry.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_out.valid <= 1'b0;
    end else begin
      q_out.valid <= q_next.valid;
    end
    q_out.addr <= q_next.addr;
    q_out.mem  <= q_next.mem;
    q_out.hit  <= q_next.hit;
    q_out.data <= q_next.data;
  end

endmodule
